>>> rtl/rgb3x3_pkg.sv
// shared types and constants of the rgb 3x3 convolution filter
// no dependencies
`timescale 1ns / 1ps

package rgb3x3_pkg;

  localparam int DEF_MAX_WIDTH      = 1024;
  localparam int DEF_COEF_FRAC_BITS = 8;

  localparam int PIX_W     = 8;
  localparam int PIXEL_W   = 3 * PIX_W;
  localparam int ENTRY_W   = 2 * PIXEL_W;
  localparam int COEF_W    = 16;
  localparam int KROW_W    = 3 * COEF_W;
  localparam int PROD_W    = PIX_W + 1 + COEF_W;
  localparam int SUM_W     = PROD_W + 4;
  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 13;
  localparam int ROW_W     = 12;
  localparam int ROW_LIMIT = 4096;
  localparam int MIN_DIM   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int PIX_MAX   = 255;

  localparam logic [KROW_W-1:0] KMID_RESET = 48'h0000_0100_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KTOP   = 3'd0,
    REG_KMID   = 3'd1,
    REG_KBOT   = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } cfg_reg_t;

  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

>>> rtl/rgb_3x3_convolution_clamp_top.sv
// rgb 3x3 convolution filter with clamp to 0..255, one pixel per clock when not stalled
// depends on rgb3x3_pkg
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid / in_ready, one pixel per beat in raster order,
//   frame_start high on the first pixel of a frame. Output channel:
//   out_valid / out_ready, one filtered pixel per interior input pixel, so a
//   frame of W x H pixels gives (W-2) x (H-2) results, frame_last on the last.
//   Configuration: cfg_valid / cfg_ready (always ready), cfg_index selects
//   kernel rows 0..2, width 3 and height 4; write only while the block idles.
//   Throughput: one pixel per clock when not stalled, set by the line store,
//   which takes one read and one write per pixel in the same clock on
//   separate ports. Pipeline: an accepted pixel goes through the input stage
//   with line store read, the product stage, and sum and clamp into out_ch.
//   Stall: a low out_ready while out_valid is high freezes all stages and
//   drops in_ready in the same cycle; nothing is lost. Reset clears counters,
//   window, valid bits and the registers to identity kernel and 1024 x 1024;
//   the line store holds no reset value and is filled by the first two rows.

module rgb_3x3_convolution_clamp_top #(
  parameter int MAX_WIDTH      = rgb3x3_pkg::DEF_MAX_WIDTH,
  parameter int COEF_FRAC_BITS = rgb3x3_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rgb3x3_pkg::PIX_W-1:0]     pixel_ch0,
  input  logic [rgb3x3_pkg::PIX_W-1:0]     pixel_ch1,
  input  logic [rgb3x3_pkg::PIX_W-1:0]     pixel_ch2,
  input  logic                             frame_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rgb3x3_pkg::PIX_W-1:0]     out_ch0,
  output logic [rgb3x3_pkg::PIX_W-1:0]     out_ch1,
  output logic [rgb3x3_pkg::PIX_W-1:0]     out_ch2,
  output logic                             frame_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rgb3x3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgb3x3_pkg::KROW_W-1:0]    cfg_data
);
  import rgb3x3_pkg::*;

  localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMPW = (AW + 1 > IMG_W_W) ? AW + 1 : IMG_W_W;
  localparam logic signed [SUM_W-1:0] SAT_LIM =
    SUM_W'(PIX_MAX + 1) <<< COEF_FRAC_BITS;

  // configuration registers
  logic [KROW_W-1:0]  kernel_row_top, kernel_row_mid, kernel_row_bottom;
  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_row_top    <= '0;
      kernel_row_mid    <= KMID_RESET;
      kernel_row_bottom <= '0;
      image_width       <= IMG_W_W'(1024);
      image_height      <= IMG_H_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_KTOP:   kernel_row_top    <= cfg_data;
        REG_KMID:   kernel_row_mid    <= cfg_data;
        REG_KBOT:   kernel_row_bottom <= cfg_data;
        REG_WIDTH:  image_width       <= cfg_data[IMG_W_W-1:0];
        REG_HEIGHT: image_height      <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated frame size
  logic [CMPW-1:0]    w_sat;
  logic [IMG_H_W-1:0] h_sat;

  always_comb begin
    if (image_width < IMG_W_W'(MIN_DIM)) begin
      w_sat = CMPW'(MIN_DIM);
    end else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) begin
      w_sat = CMPW'(MAX_WIDTH);
    end else begin
      w_sat = CMPW'(image_width);
    end
    if (image_height < IMG_H_W'(MIN_DIM)) begin
      h_sat = IMG_H_W'(MIN_DIM);
    end else if (image_height > IMG_H_W'(ROW_LIMIT)) begin
      h_sat = IMG_H_W'(ROW_LIMIT);
    end else begin
      h_sat = image_height;
    end
  end

  // pipeline control
  logic advance, accept;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  // position counters
  logic [AW-1:0]    col_count, col_count_next, c_eff;
  logic [ROW_W-1:0] row_count, row_count_next, r_eff;
  logic             row_end, frame_end, emit, last;

  always_comb begin
    c_eff     = frame_start ? '0 : col_count;
    r_eff     = frame_start ? '0 : row_count;
    row_end   = (CMPW'(c_eff) + CMPW'(1)) >= w_sat;
    frame_end = (IMG_H_W'(r_eff) + IMG_H_W'(1)) >= h_sat;
    emit      = (r_eff >= ROW_W'(2)) && (CMPW'(c_eff) >= CMPW'(2));
    last      = row_end && frame_end;
    if (row_end) begin
      col_count_next = '0;
      row_count_next = frame_end ? '0 : r_eff + ROW_W'(1);
    end else begin
      col_count_next = c_eff + AW'(1);
      row_count_next = r_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // input stage
  logic               s1_valid, s1_emit, s1_last;
  logic [AW-1:0]      s1_addr;
  logic [PIXEL_W-1:0] s1_pix;
  logic [ENTRY_W-1:0] s1_wdata, rd_mem, fwd_data, entry;
  logic               fwd;
  logic               s1_write;

  // line store
  logic [ENTRY_W-1:0] row_store [MAX_WIDTH];

  assign s1_write = s1_valid && advance;
  assign entry    = fwd ? fwd_data : rd_mem;
  assign s1_wdata = {entry[PIXEL_W-1:0], s1_pix};

  always_ff @(posedge clk) begin
    if (s1_write) begin
      row_store[s1_addr] <= s1_wdata;
    end
    if (accept) begin
      rd_mem <= row_store[c_eff];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
      fwd      <= accept && s1_valid && (s1_addr == c_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr  <= c_eff;
      s1_pix   <= {pixel_ch2, pixel_ch1, pixel_ch0};
      s1_emit  <= emit;
      s1_last  <= last;
      fwd_data <= s1_wdata;
    end
  end

  // window, two previous columns: index col * 3 + row
  logic [PIXEL_W-1:0] win [6];
  logic [PIXEL_W-1:0] cur [3];

  assign cur[0] = entry[ENTRY_W-1:PIXEL_W];
  assign cur[1] = entry[PIXEL_W-1:0];
  assign cur[2] = s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) win[k] <= '0;
    end else if (s1_write) begin
      for (int k = 0; k < 3; k++) begin
        win[k]     <= win[3 + k];
        win[3 + k] <= cur[k];
      end
    end
  end

  // products
  logic [KROW_W-1:0] krow [3];
  prod_t             prod      [3][3][3];
  prod_t             prod_next [3][3][3];
  logic              s2_valid, s2_last;

  assign krow[0] = kernel_row_top;
  assign krow[1] = kernel_row_mid;
  assign krow[2] = kernel_row_bottom;

  always_comb begin
    logic [PIXEL_W-1:0]       p;
    logic signed [PIX_W:0]    v;
    logic signed [COEF_W-1:0] cf;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          p  = (l == 2) ? cur[k] : win[l * 3 + k];
          v  = $signed({1'b0, p[ch*PIX_W +: PIX_W]});
          cf = $signed(krow[k][l*COEF_W +: COEF_W]);
          prod_next[ch][k][l] = PROD_W'(v * cf);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod    <= prod_next;
      s2_last <= s1_last;
    end
  end

  // sum, floor and clamp
  logic [PIX_W-1:0] res [3];

  always_comb begin
    logic signed [SUM_W-1:0] rsum [3];
    logic signed [SUM_W-1:0] tot;
    logic signed [SUM_W-1:0] q;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 3; k++) begin
        rsum[k] = SUM_W'(prod[ch][k][0]) + SUM_W'(prod[ch][k][1])
                + SUM_W'(prod[ch][k][2]);
      end
      tot = rsum[0] + rsum[1] + rsum[2];
      q   = tot >>> COEF_FRAC_BITS;
      if (tot < 0) begin
        res[ch] = '0;
      end else if (tot >= SAT_LIM) begin
        res[ch] = PIX_W'(PIX_MAX);
      end else begin
        res[ch] = q[PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch0    <= res[0];
      out_ch1    <= res[1];
      out_ch2    <= res[2];
      frame_last <= s2_last;
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted beat missing from input stage");

  a_fwd_has_item: assert property (@(posedge clk) disable iff (rst)
    fwd |-> s1_valid)
    else $error("line store bypass without item in input stage");

  a_s2_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(s2_valid) |-> $past(s1_valid && s1_emit))
    else $error("product stage valid without emitting input item");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    accept |=> (CMPW'(col_count) < CMPW'(MAX_WIDTH)))
    else $error("column count beyond line store depth");

endmodule
